/* hw/rtl/ifr_pkg.sv */
// ifr_pkg: shared types and codes for the bus frame receiver
// no dependencies
package ifr_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] ST_DATA   = 2'd0;
    localparam logic [1:0] ST_GOOD   = 2'd1;
    localparam logic [1:0] ST_BADSUM = 2'd2;
    localparam logic [1:0] ST_BADLEN = 2'd3;

    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_byte;
        logic [7:0] source_addr;
        logic [7:0] dest_addr;
        logic       frame_end;
    } ifr_result_t;

endpackage

/* hw/rtl/ifr_front.sv */
// ifr_front: byte classifier and frame state, one beat per cycle while the queue has space
// depends on ifr_pkg
module ifr_front import ifr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        q_ready,
    output logic        q_push,
    output ifr_result_t q_data
);

    localparam logic [2:0] PH_SOURCE   = 3'd0;
    localparam logic [2:0] PH_LENGTH   = 3'd1;
    localparam logic [2:0] PH_DEST     = 3'd2;
    localparam logic [2:0] PH_DATA     = 3'd3;
    localparam logic [2:0] PH_CHECK    = 3'd4;
    localparam logic [2:0] PH_DEST_BAD = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] src_reg, src_next;
    logic [7:0] dst_reg, dst_next;
    logic       accept;
    logic       has_result;
    logic [1:0] res_status;
    logic [7:0] res_data;
    logic       res_end;
    logic [7:0] rem_dec;

    assign s_ready = q_ready;
    assign accept  = s_valid & q_ready;
    assign rem_dec = remaining_reg - 8'd1;

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        xor_next       = xor_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        has_result     = 1'b0;
        res_status     = ST_DATA;
        res_data       = 8'd0;
        res_end        = 1'b0;
        unique case (phase_reg)
            PH_LENGTH: begin
                xor_next = xor_reg ^ s_rx_byte;
                if (s_rx_byte < LEN_OVERHEAD) begin
                    remaining_next = 8'd0;
                    phase_next     = PH_DEST_BAD;
                end else begin
                    remaining_next = s_rx_byte - LEN_OVERHEAD;
                    phase_next     = PH_DEST;
                end
            end
            PH_DEST: begin
                dst_next   = s_rx_byte;
                xor_next   = xor_reg ^ s_rx_byte;
                phase_next = (remaining_reg == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DEST_BAD: begin
                dst_next   = s_rx_byte;
                xor_next   = xor_reg ^ s_rx_byte;
                phase_next = PH_SOURCE;
                has_result = 1'b1;
                res_status = ST_BADLEN;
                res_end    = 1'b1;
            end
            PH_DATA: begin
                xor_next       = xor_reg ^ s_rx_byte;
                remaining_next = rem_dec;
                if (rem_dec == 8'd0) begin
                    phase_next = PH_CHECK;
                end
                has_result = 1'b1;
                res_data   = s_rx_byte;
            end
            PH_CHECK: begin
                phase_next = PH_SOURCE;
                has_result = 1'b1;
                res_status = (s_rx_byte == xor_reg) ? ST_GOOD : ST_BADSUM;
                res_end    = 1'b1;
            end
            default: begin
                src_next       = s_rx_byte;
                xor_next       = s_rx_byte;
                remaining_next = 8'd0;
                phase_next     = PH_LENGTH;
            end
        endcase
    end

    assign q_push = accept & has_result;

    always_comb begin
        q_data.status      = res_status;
        q_data.data_byte   = res_data;
        q_data.source_addr = src_next;
        q_data.dest_addr   = dst_next;
        q_data.frame_end   = res_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SOURCE;
            remaining_reg <= 8'd0;
            xor_reg       <= 8'd0;
            src_reg       <= 8'd0;
            dst_reg       <= 8'd0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            xor_reg       <= xor_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
        end
    end

    a_data_only_in_data_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_data.status == ST_DATA) |-> (phase_reg == PH_DATA && !q_data.frame_end))
        else $error("data beat outside data phase");

    a_bad_len_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_LENGTH && s_rx_byte < LEN_OVERHEAD)
        |=> (phase_reg == PH_DEST_BAD && remaining_reg == 8'd0))
        else $error("short length did not enter bad destination phase");

endmodule

/* hw/rtl/ifr_queue.sv */
// ifr_queue: short result queue between front and back
// depends on ifr_pkg
module ifr_queue import ifr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  ifr_result_t push_data,
    output logic        can_push,
    input  logic        pop,
    output logic        not_empty,
    output ifr_result_t head
);

    ifr_result_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg;
    logic [QPTR_W-1:0]        rd_ptr_reg;
    logic [QCNT_W-1:0]        count_reg, count_next;

    assign can_push  = (count_reg != QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (can_push || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");

endmodule

/* hw/rtl/ifr_back.sv */
// ifr_back: output register stage driving the result channel
// depends on ifr_pkg
module ifr_back import ifr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_not_empty,
    input  ifr_result_t q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output ifr_result_t m_data
);

    logic        valid_reg;
    ifr_result_t out_reg;

    assign q_pop   = q_not_empty & (~valid_reg | m_ready);
    assign m_valid = valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |-> !q_pop)
        else $error("output register overwritten while stalled");

endmodule

/* hw/rtl/ibus_frame_receiver_top.sv */
// ibus_frame_receiver_top: frame parser for an xor-checked serial bus
// depends on ifr_pkg, ifr_front, ifr_queue, ifr_back
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_rx_byte[7:0]
// m_       out  m_valid/m_ready    m_status, m_data_byte, m_source_addr,
//                                  m_dest_addr, m_frame_end
//
// one beat per cycle in and out while neither side stalls; each result is
// written into the queue, then loaded into the output register
// aresetn is synchronous: frame state returns to expect-source, queue empties
// s_ready follows queue space only, so a stalled m_ side backs up through a
// two-entry queue and the output register before input stalls
module ibus_frame_receiver_top import ifr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_source_addr,
    output logic [7:0] m_dest_addr,
    output logic       m_frame_end
);

    logic        q_can_push;
    logic        q_push;
    ifr_result_t q_in;
    logic        q_pop;
    logic        q_not_empty;
    ifr_result_t q_head;
    ifr_result_t m_data;

    ifr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_ready   (q_can_push),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    ifr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .can_push  (q_can_push),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ifr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    assign m_status      = m_data.status;
    assign m_data_byte   = m_data.data_byte;
    assign m_source_addr = m_data.source_addr;
    assign m_dest_addr   = m_data.dest_addr;
    assign m_frame_end   = m_data.frame_end;

endmodule
